@@ rtl/zsp_pkg.sv @@
package zsp_pkg;

  localparam int VALUE_BITS    = 8;
  localparam int MAX_ITEMS     = 1024;
  localparam int IN_DATA_BITS  = 8;
  localparam int HIST_DEPTH    = 1 << VALUE_BITS;
  localparam int HALF_BITS     = VALUE_BITS - 1;
  localparam int CNT_BITS      = $clog2(MAX_ITEMS + 1);
  localparam int PROD_BITS     = 2 * CNT_BITS;
  localparam int ACC_BITS      = 2 * CNT_BITS;
  localparam int PAIR_BITS     = 19;
  localparam int PAIR_MAX      = (1 << PAIR_BITS) - 1;
  localparam int OUT_DATA_BITS = ((PAIR_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic accept;
    logic load_wr;
    logic scan_step;
    logic finish;
  } zsp_cmd_t;

  typedef struct packed {
    logic last;
    logic scan_end;
    logic pipe_busy;
    logic out_free;
  } zsp_sts_t;

endpackage

@@ rtl/zsp_ram.sv @@
module zsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/zsp_ctrl.sv @@
module zsp_ctrl import zsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  zsp_sts_t  sts_i,
  output zsp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_LOAD_WR = 4'b0010,
    ST_SCAN    = 4'b0100,
    ST_DRAIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_LOAD_WR;
        end
      end
      ST_LOAD_WR: begin
        cmd_o.load_wr = 1'b1;
        state_d = sts_i.last ? ST_SCAN : ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the multiply-accumulate pipe and a free output slot
        if (!sts_i.pipe_busy && sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

@@ rtl/zsp_dp.sv @@
module zsp_dp import zsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  zsp_cmd_t                cmd_i,
  output zsp_sts_t                sts_o,
  input  logic [IN_DATA_BITS-1:0] in_value_i,
  input  logic                    in_last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [PAIR_BITS-1:0]    out_pair_count_o,
  output logic                    out_too_many_o
);

  logic [VALUE_BITS-1:0] in_idx;
  logic [VALUE_BITS-1:0] rd_addr_a, rd_addr_b;
  logic [CNT_BITS-1:0]   rd_data_a, rd_data_b;
  logic [CNT_BITS-1:0]   hist_a, hist_b, mul_b;
  logic                  ram_we;

  logic [VALUE_BITS-1:0] idx_q;
  logic                  last_q, cnt_ok_q;
  logic [CNT_BITS-1:0]   items_q;
  logic                  overflow_q;
  logic [HIST_DEPTH-1:0] valid_q;
  logic                  vld_a_q, vld_b_q;
  logic [HALF_BITS-1:0]  v_q;
  logic                  rd_pend_q, rd_zero_q;
  logic [PROD_BITS-1:0]  prod_q;
  logic                  prod_vld_q, prod_zero_q;
  logic [ACC_BITS-1:0]   acc_q;
  logic [ACC_BITS-1:0]   acc_add;
  logic                  out_vld_q, out_tm_q;
  logic [PAIR_BITS-1:0]  out_pc_q;
  logic [PAIR_BITS-1:0]  pair_sat;

  // low bits of the value, sign extended to the histogram index width
  assign in_idx = VALUE_BITS'($signed(in_value_i));

  assign rd_addr_a = cmd_i.scan_step ? {1'b0, v_q} : in_idx;
  assign rd_addr_b = VALUE_BITS'(0) - {1'b0, v_q};
  assign ram_we    = cmd_i.load_wr && cnt_ok_q;

  zsp_ram #(
    .WIDTH (CNT_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (idx_q),
    .wdata_i   (hist_a + CNT_BITS'(1)),
    .raddr_a_i (rd_addr_a),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_data_a),
    .rdata_b_o (rd_data_b)
  );

  // entries not written since the last set read as zero
  assign hist_a = vld_a_q ? rd_data_a : '0;
  assign hist_b = vld_b_q ? rd_data_b : '0;

  // zero pairs with itself: count * (count - 1), halved after the multiply
  always_comb begin
    if (rd_zero_q) begin
      mul_b = (hist_a == '0) ? '0 : hist_a - CNT_BITS'(1);
    end else begin
      mul_b = hist_b;
    end
  end

  assign acc_add  = prod_zero_q ? ACC_BITS'(prod_q >> 1) : ACC_BITS'(prod_q);
  assign pair_sat = (acc_q > ACC_BITS'(PAIR_MAX)) ? PAIR_BITS'(PAIR_MAX)
                                                 : acc_q[PAIR_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= in_idx;
    end
    prod_q      <= PROD_BITS'(hist_a) * PROD_BITS'(mul_b);
    prod_zero_q <= rd_zero_q;
    if (cmd_i.finish) begin
      out_pc_q <= pair_sat;
      out_tm_q <= overflow_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= 1'b0;
      cnt_ok_q   <= 1'b0;
      items_q    <= '0;
      overflow_q <= 1'b0;
      valid_q    <= '0;
      vld_a_q    <= 1'b0;
      vld_b_q    <= 1'b0;
      v_q        <= '0;
      rd_pend_q  <= 1'b0;
      rd_zero_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      vld_a_q    <= valid_q[rd_addr_a];
      vld_b_q    <= valid_q[rd_addr_b];
      rd_pend_q  <= cmd_i.scan_step;
      rd_zero_q  <= cmd_i.scan_step && (v_q == '0);
      prod_vld_q <= rd_pend_q;
      if (cmd_i.accept) begin
        last_q   <= in_last_i;
        cnt_ok_q <= (items_q < CNT_BITS'(MAX_ITEMS));
      end
      if (cmd_i.load_wr) begin
        if (cnt_ok_q) begin
          valid_q[idx_q] <= 1'b1;
          items_q        <= items_q + CNT_BITS'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (cmd_i.scan_step) begin
        v_q <= v_q + HALF_BITS'(1);
      end
      if (prod_vld_q) begin
        acc_q <= acc_q + acc_add;
      end
      if (cmd_i.finish) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        valid_q    <= '0;
        items_q    <= '0;
        overflow_q <= 1'b0;
        acc_q      <= '0;
      end
    end
  end

  assign sts_o.last      = last_q;
  assign sts_o.scan_end  = (v_q == '1);
  assign sts_o.pipe_busy = rd_pend_q || prod_vld_q;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o      = out_vld_q;
  assign out_pair_count_o = out_pc_q;
  assign out_too_many_o   = out_tm_q;

endmodule

@@ rtl/zero_sum_pair_counter.sv @@
// channel   dir  tdata                       tlast  tuser
// s_axis    in   [7:0] value                 last   -
// m_axis    out  [18:0] pair_count, rest 0   -      too_many
//
// each value takes a histogram read, then a write of the count plus one; the next value waits for that write
// the item marked last adds a scan of the histogram (two histogram reads a cycle),
// a multiply-accumulate flush and a load of the result
// reset clears the per-entry valid bits, so the histogram reads as zero at once
// a result not yet taken holds the block before its next scan result is loaded
module zero_sum_pair_counter import zsp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata_i,  // [7:0] value
  input  logic                     s_axis_tlast_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata_o,  // [18:0] pair_count, zero above
  output logic                     m_axis_tuser_o   // [0] too_many
);

  zsp_cmd_t             cmd;
  zsp_sts_t             sts;
  logic [PAIR_BITS-1:0] pair_count;

  zsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  zsp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_value_i       (s_axis_tdata_i),
    .in_last_i        (s_axis_tlast_i),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_pair_count_o (pair_count),
    .out_too_many_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = OUT_DATA_BITS'(pair_count);

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.load_wr, cmd.scan_step, cmd.finish}))
    else $error("controller issued overlapping commands");

  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> m_axis_tvalid_o)
    else $error("finished set did not produce a result");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !sts.pipe_busy)
    else $error("input accepted while scan pipe still busy");

  a_finish_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !sts.pipe_busy && sts.out_free)
    else $error("result loaded before accumulation completed");

endmodule
